[rtl/sgd_polynomial_regression_trainer_assert.svh]
// Assertion helpers for the trainer.
`ifndef SGD_POLYNOMIAL_REGRESSION_TRAINER_ASSERT_SVH
`define SGD_POLYNOMIAL_REGRESSION_TRAINER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SGD_ASSERT(label, clk, rst, prop, msg) \
label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SGD_ASSERT_NEVER(label, clk, rst, cond, msg) \
label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SGD_ASSERT(label, clk, rst, prop, msg)
`define SGD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/sgd_pkg.sv]
`default_nettype none
package sgd_pkg;

   localparam int F_W    = 16;   // Q1.15 features
   localparam int W_W    = 32;   // Q8.24 weights and values
   localparam int SUM_W  = 48;   // epoch gradient sums
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_SQ    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURES_USED   = 2'd2;

   localparam logic [15:0] LR_RESET  = 16'd66;
   localparam logic [31:0] THR_RESET = 32'd28147;
   localparam logic [1:0]  FU_RESET  = 2'd1;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quot;
   } div_stat_type;

endpackage
`default_nettype wire

[rtl/sgd_req_if.sv]
`default_nettype none
interface sgd_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] x_first;
   logic signed [15:0] x_second;
   logic signed [31:0] target_value;
   logic               last_of_epoch;

   modport source (output valid, mode, x_first, x_second, target_value, last_of_epoch,
                   input ready);
   modport sink   (input valid, mode, x_first, x_second, target_value, last_of_epoch,
                   output ready);
endinterface
`default_nettype wire

[rtl/sgd_rsp_if.sv]
`default_nettype none
interface sgd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] prediction;
   logic               epoch_done;
   logic               converged;

   modport source (output valid, prediction, epoch_done, converged, input ready);
   modport sink   (input valid, prediction, epoch_done, converged, output ready);
endinterface
`default_nettype wire

[rtl/sgd_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sgd_div #(
   parameter int DIVISOR_W = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sgd_pkg::SUM_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output sgd_pkg::div_stat_type       stat
);
   import sgd_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W:0] shifted, diff;
   logic               ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[SUM_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      rem_in  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      dvd_in  = {dvd_ff[SUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SUM_W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = dvd_ff;
endmodule
`default_nettype wire

[rtl/sgd_polynomial_regression_trainer.sv]
// Channel   Dir  Carries
// req_bus   in   mode, x_first, x_second, target_value, last_of_epoch
// rsp_bus   out  prediction, epoch_done, converged
// csr_*     in   learning_rate (0), threshold_squared (1), features_used (2)
//
// One request at a time, NW = 2*POLY_DEGREE+1 weights.
// Predict makes one pass over the weights after the feature powers; train makes a
// second pass, as the single read port of the weight/sum memories walks every entry twice.
// Closing an epoch runs every gradient sum through the bit-serial divider.
// Reset is synchronous; memory entries carry valid bits, so no clearing pass.
// A finished response waits in the output register while the next request is taken.
`default_nettype none
`include "sgd_polynomial_regression_trainer_assert.svh"
module sgd_polynomial_regression_trainer #(
   parameter int POLY_DEGREE = 5,
   parameter int COUNT_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   sgd_req_if.sink                          req_bus,
   sgd_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [sgd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sgd_pkg::*;

   localparam int NW    = 2 * POLY_DEGREE + 1;
   localparam int IDX_W = $clog2(NW);
   localparam int ACC_W = 52;   // up to 16 products of 2^46
   localparam int G_W   = 34;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NW - 1);
   localparam logic [IDX_W-1:0] POW_LAST = IDX_W'(POLY_DEGREE - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_POW, ST_PRED, ST_ERR, ST_UPD,
      ST_NRD, ST_NSTART, ST_NDIV, ST_NSQ, ST_NACC, ST_OUT
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
      if (v > 17'sd32767)       return 16'sh7FFF;
      else if (v < -17'sd32768) return 16'sh8000;
      else                      return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sh0_7FFF_FFFF)      return 32'sh7FFF_FFFF;
      else if (v < -38'sh0_8000_0000) return 32'sh8000_0000;
      else                            return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      if (v[48] != v[47]) return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else                return v[47:0];
   endfunction

   // config
   logic [15:0] lr_ff;
   logic [31:0] thr_ff;
   logic [1:0]  fu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         thr_ff <= THR_RESET;
         fu_ff  <= FU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: lr_ff  <= csr_wdata[15:0];
            CSR_THRESHOLD_SQ:  thr_ff <= csr_wdata[31:0];
            CSR_FEATURES_USED: fu_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff;

   // request latch
   logic               mode_ff, last_ff, two_ff;
   logic signed [15:0] x1_ff, x2_ff, p1_ff, p2_ff;
   logic signed [31:0] tgt_ff;
   logic signed [15:0] f_ff [NW];

   // pass pipeline tags
   logic [IDX_W-1:0] idx_ff, s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic             iss_ff, s1_vld_ff, s2_vld_ff, s3_vld_ff;

   // datapath
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [31:0]      w0_ff, pred_ff;
   logic signed [32:0]      e_ff;
   logic signed [48:0]      prod1_ff;
   logic signed [G_W-1:0]   g_ff;
   logic signed [50:0]      step_ff;
   logic signed [31:0]      wv_ff, wv2_ff;
   logic signed [47:0]      sv_ff, sv2_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic                    conv_ff, done_ff, big_ff;
   logic [63:0]             norm_ff, sq_ff;

   // output register
   logic               rsp_vld_ff, rsp_done_ff, rsp_conv_ff;
   logic signed [31:0] rsp_pred_ff;

   // memories
   logic signed [31:0] w_mem [NW];
   logic signed [47:0] s_mem [NW];
   logic [NW-1:0]      w_vld_ff, s_vld_ff;
   logic signed [31:0] w_rd_ff;
   logic signed [47:0] s_rd_ff;
   logic               w_rv_ff, s_rv_ff;

   logic signed [31:0] w_cur, w_new;
   logic signed [47:0] s_cur, s_new;
   logic               mem_we, clr_sums;

   logic signed [31:0] pw1, pw2;
   logic signed [37:0] pred_sum;
   logic signed [31:0] pred_in;
   logic signed [48:0] prod1_in;
   logic signed [G_W-1:0] g_in;
   logic [SUM_W-1:0]   mag;
   logic [64:0]        norm_sum;
   logic               div_start;
   div_stat_type       div_stat;

   always_comb begin
      w_cur    = w_rv_ff ? w_rd_ff : 32'sd0;
      s_cur    = s_rv_ff ? s_rd_ff : 48'sd0;
      pw1      = p1_ff * x1_ff;
      pw2      = p2_ff * x2_ff;
      pred_sum = $signed({{6{w0_ff[31]}}, w0_ff}) + 38'($signed(acc_ff[ACC_W-1:15]));
      pred_in  = sat32(pred_sum);
      if (state_ff == ST_PRED) begin
         prod1_in = w_cur * f_ff[s1_idx_ff];
      end else begin
         prod1_in = e_ff * f_ff[s1_idx_ff];
      end
      g_in     = (s2_idx_ff == '0) ? G_W'(e_ff) : prod1_ff[48:15];
      w_new    = sat32($signed({{6{wv2_ff[31]}}, wv2_ff}) - 38'($signed(step_ff[50:16])));
      s_new    = sat48($signed({sv2_ff[47], sv2_ff}) + 49'(g_ff));
      mag      = s_cur[47] ? SUM_W'(-s_cur) : SUM_W'(s_cur);
      norm_sum = {1'b0, norm_ff} + {1'b0, sq_ff};
      mem_we   = s3_vld_ff;
      clr_sums = (state_ff == ST_NACC) && (idx_ff == LAST_IDX);
      div_start = (state_ff == ST_NSTART);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         w_mem[s3_idx_ff] <= w_new;
         s_mem[s3_idx_ff] <= s_new;
      end
      w_rd_ff <= w_mem[idx_ff];
      s_rd_ff <= s_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= '0;
         s_vld_ff <= '0;
         w_rv_ff  <= 1'b0;
         s_rv_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            w_vld_ff[s3_idx_ff] <= 1'b1;
            s_vld_ff[s3_idx_ff] <= 1'b1;
         end
         if (clr_sums) s_vld_ff <= '0;
         w_rv_ff <= w_vld_ff[idx_ff];
         s_rv_ff <= s_vld_ff[idx_ff];
      end
   end

   sgd_div #(.DIVISOR_W(COUNT_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (count_ff),
      .stat     (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         iss_ff     <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         count_ff   <= '0;
         conv_ff    <= 1'b0;
         done_ff    <= 1'b0;
         big_ff     <= 1'b0;
         idx_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // read pipeline: issue at idx, data in the next cycle
         s1_vld_ff <= iss_ff;
         s1_idx_ff <= idx_ff;
         s2_vld_ff <= s1_vld_ff;
         s2_idx_ff <= s1_idx_ff;
         s3_vld_ff <= s2_vld_ff && (state_ff == ST_UPD);
         s3_idx_ff <= s2_idx_ff;
         if (iss_ff) begin
            if (idx_ff == LAST_IDX) iss_ff <= 1'b0;
            else                    idx_ff <= idx_ff + 1'b1;
         end
         if (s1_vld_ff) begin
            prod1_ff <= prod1_in;
            wv_ff    <= w_cur;
            sv_ff    <= s_cur;
            if (s1_idx_ff == '0) w0_ff <= w_cur;
         end
         if (s2_vld_ff) begin
            acc_ff  <= acc_ff + ACC_W'($signed(prod1_ff[47:0]));
            g_ff    <= g_in;
            step_ff <= $signed({1'b0, lr_ff}) * g_in;
            wv2_ff  <= wv_ff;
            sv2_ff  <= sv_ff;
         end

         // ST_OUT reloads the output register itself
         if (rsp_vld_ff && rsp_bus.ready && (state_ff != ST_OUT)) rsp_vld_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  mode_ff  <= req_bus.mode;
                  last_ff  <= req_bus.last_of_epoch;
                  x1_ff    <= req_bus.x_first;
                  x2_ff    <= req_bus.x_second;
                  p1_ff    <= req_bus.x_first;
                  p2_ff    <= req_bus.x_second;
                  tgt_ff   <= req_bus.target_value;
                  two_ff   <= fu_ff[1];
                  f_ff[0]  <= 16'sd0;
                  idx_ff   <= '0;
                  done_ff  <= 1'b0;
                  state_ff <= ST_POW;
               end
            end
            ST_POW: begin
               f_ff[IDX_W'(1) + idx_ff] <= p1_ff;
               f_ff[IDX_W'(POLY_DEGREE + 1) + idx_ff] <= two_ff ? p2_ff : 16'sd0;
               p1_ff <= sat16(pw1[31:15]);
               p2_ff <= sat16(pw2[31:15]);
               if (idx_ff == POW_LAST) begin
                  idx_ff   <= '0;
                  iss_ff   <= 1'b1;
                  acc_ff   <= '0;
                  state_ff <= ST_PRED;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_PRED: begin
               if (s2_vld_ff && (s2_idx_ff == LAST_IDX)) state_ff <= ST_ERR;
            end
            ST_ERR: begin
               pred_ff <= pred_in;
               e_ff    <= {pred_in[31], pred_in} - {tgt_ff[31], tgt_ff};
               if (!mode_ff && !conv_ff) begin
                  if (count_ff != '1) count_ff <= count_ff + 1'b1;
                  idx_ff   <= '0;
                  iss_ff   <= 1'b1;
                  state_ff <= ST_UPD;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_UPD: begin
               if (s3_vld_ff && (s3_idx_ff == LAST_IDX)) begin
                  idx_ff  <= '0;
                  norm_ff <= '0;
                  big_ff  <= 1'b0;
                  state_ff <= last_ff ? ST_NRD : ST_OUT;
               end
            end
            ST_NRD:    state_ff <= ST_NSTART;
            ST_NSTART: state_ff <= ST_NDIV;
            ST_NDIV: begin
               if (div_stat.done) state_ff <= ST_NSQ;
            end
            ST_NSQ: begin
               if (div_stat.quot[SUM_W-1:32] != '0) big_ff <= 1'b1;
               sq_ff    <= div_stat.quot[31:0] * div_stat.quot[31:0];
               state_ff <= ST_NACC;
            end
            ST_NACC: begin
               norm_ff <= norm_sum[63:0];
               if (norm_sum[64]) big_ff <= 1'b1;
               if (idx_ff == LAST_IDX) begin
                  // epoch close: test, clear sums and count
                  if (!big_ff && !norm_sum[64] && (norm_sum[63:0] < {32'd0, thr_ff}))
                     conv_ff <= 1'b1;
                  count_ff <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_NRD;
               end
            end
            ST_OUT: begin
               if (!rsp_vld_ff || rsp_bus.ready) begin
                  rsp_vld_ff  <= 1'b1;
                  rsp_pred_ff <= pred_ff;
                  rsp_done_ff <= done_ff;
                  rsp_conv_ff <= conv_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.prediction = rsp_pred_ff;
   assign rsp_bus.epoch_done = rsp_done_ff;
   assign rsp_bus.converged  = rsp_conv_ff;

   `SGD_ASSERT(a_wr_in_upd, clock, reset, s3_vld_ff |-> (state_ff == ST_UPD), "write outside update")
   `SGD_ASSERT_NEVER(a_conv_sticky, clock, reset, $fell(conv_ff), "converged flag dropped")
   `SGD_ASSERT(a_div_free, clock, reset, div_start |-> !div_stat.busy, "divider restarted")
   `SGD_ASSERT(a_epoch_clr, clock, reset, ((state_ff == ST_OUT) && done_ff) |-> (count_ff == '0), "count not cleared")
endmodule
`default_nettype wire

[tb/sv/tb_sgd_polynomial_regression_trainer.sv]
`default_nettype none
module tb_sgd_polynomial_regression_trainer;
   timeunit 1ns;
   timeprecision 1ps;

   import sgd_pkg::*;

   localparam int NW          = 11;        // intercept + 2 x degree-5 powers
   localparam int CNT_MAX     = 65535;     // 16-bit epoch sample count
   localparam int STALL_LIMIT = 4000;      // cycles with no handshake at all
   localparam int HOLD_CYCLES = 500;       // long receiver hold-off
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint G48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint G48_MIN = -G48_MAX - 1;
   localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_MIN = -S32_MAX - 1;

   typedef struct {
      bit                 mode;
      logic signed [15:0] xa;
      logic signed [15:0] xb;
      logic signed [31:0] tgt;
      bit                 last;
   } sample_type;

   typedef struct {
      logic signed [31:0] pred;
      bit                 done;
      bit                 conv;
   } outcome_type;

   typedef struct {
      sample_type  s;
      bit          typed;
      outcome_type o;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sgd_req_if req_if ();
   sgd_rsp_if rsp_if ();

   sgd_polynomial_regression_trainer uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the trainer state and its registers
   int            w_model [NW];
   longint        gsum_model [NW];
   int unsigned   count_model;
   bit            conv_model;
   bit [15:0]     lr_reg;
   bit [31:0]     thr_reg;
   bit [1:0]      fu_reg;

   outcome_type expected_outcomes [$];
   int       n_sent;
   int       n_checked;
   int       n_fail;
   int       idle_cycles;
   bit       hold_rsp;    // asks the receiver for one long hold-off
   bit       quiet;       // no random idling on either side
   row_type  rows [14];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Runs one request through the shadow model and returns the response it should give.
   function automatic outcome_type predict_outcome(sample_type s);
      longint            f [NW];
      longint            p, acc, pv, e, g, st, sv;
      longint unsigned   mag, m, sq, norm;
      bit                big;
      outcome_type       o;
      for (int k = 0; k < NW; k++) f[k] = 0;
      p = s.xa;
      for (int k = 1; k <= 5; k++) begin
         f[k] = p;
         p = clip((p * s.xa) >>> 15, -32768, 32767);
      end
      // features_used: 0 behaves as 1, 3 behaves as 2
      if (fu_reg[1]) begin
         p = s.xb;
         for (int k = 6; k <= 10; k++) begin
            f[k] = p;
            p = clip((p * s.xb) >>> 15, -32768, 32767);
         end
      end
      acc = 0;
      for (int k = 1; k < NW; k++) acc += longint'(w_model[k]) * f[k];
      pv = clip(longint'(w_model[0]) + (acc >>> 15), S32_MIN, S32_MAX);
      o.done = 1'b0;
      // predict mode and a frozen model leave all state alone
      if (!s.mode && !conv_model) begin
         e = pv - longint'(s.tgt);
         for (int k = 0; k < NW; k++) begin
            g  = (k == 0) ? e : ((e * f[k]) >>> 15);
            st = (longint'(lr_reg) * g) >>> 16;
            w_model[k]    = int'(clip(longint'(w_model[k]) - st, S32_MIN, S32_MAX));
            gsum_model[k] = clip(gsum_model[k] + g, G48_MIN, G48_MAX);
         end
         if (count_model < CNT_MAX) count_model++;
         if (s.last) begin
            norm = 0;
            big  = 1'b0;
            for (int k = 0; k < NW; k++) begin
               sv  = gsum_model[k];
               mag = (sv < 0) ? longint'(-sv) : sv;
               m   = mag / count_model;
               if (m > 64'hFFFF_FFFF) begin
                  big = 1'b1;
                  break;
               end
               sq = m * m;
               if (norm > ~64'd0 - sq) begin
                  big = 1'b1;
                  break;
               end
               norm += sq;
            end
            if (!big && norm < thr_reg) conv_model = 1'b1;
            for (int k = 0; k < NW; k++) gsum_model[k] = 0;
            count_model = 0;
            o.done = 1'b1;
         end
      end
      o.pred = pv[31:0];
      o.conv = conv_model;
      return o;
   endfunction

   // Offers one request; the expectation is queued at the edge that accepts it.
   task automatic send(sample_type s, bit typed, outcome_type typed_o);
      int          gap;
      outcome_type o;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= s.mode;
      req_if.x_first       <= s.xa;
      req_if.x_second      <= s.xb;
      req_if.target_value  <= s.tgt;
      req_if.last_of_epoch <= s.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      o = predict_outcome(s);
      expected_outcomes.push_back(typed ? typed_o : o);
      n_sent++;
   endtask

   // Waits until every response is back so the registers may be written.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (n_checked != n_sent) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_regs(bit [15:0] lr, bit [31:0] thr, bit [1:0] fu, bit probe);
      csr_we    <= 1'b1;
      csr_index <= CSR_LEARNING_RATE;
      csr_wdata <= {16'd0, lr};
      @(posedge clock);
      lr_reg = lr;
      csr_index <= CSR_THRESHOLD_SQ;
      csr_wdata <= thr;
      @(posedge clock);
      thr_reg = thr;
      csr_index <= CSR_FEATURES_USED;
      csr_wdata <= {30'd0, fu};
      @(posedge clock);
      fu_reg = fu;
      if (probe) begin
         // an index past the register list must change nothing
         csr_index <= CSR_UNUSED;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random epochs: mostly well-formed runs ending in last_of_epoch, some noise.
   task automatic run_epochs(int n_items, bit zero_targets);
      int          done_items;
      int          len;
      sample_type  s;
      outcome_type none;
      none = '{default: 0};
      done_items = 0;
      while (done_items < n_items) begin
         len = $urandom_range(1, 12);
         for (int j = 0; j < len; j++) begin
            s.mode = ($urandom_range(0, 9) == 0);
            s.xa   = 16'($urandom);
            s.xb   = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
               s.tgt = $urandom;
            else if (zero_targets)
               s.tgt = 0;
            else
               s.tgt = (32'(s.xa) <<< 8) - (32'(s.xb) <<< 6) + $urandom_range(0, 255);
            s.last = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : (j == len - 1);
            send(s, 1'b0, none);
            done_items++;
         end
      end
   endtask

   // response checker and no-progress watchdog
   always @(posedge clock) begin
      outcome_type x;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response with no request outstanding");
               n_fail++;
            end else begin
               x = expected_outcomes.pop_front();
               if (rsp_if.prediction !== x.pred) begin
                  $error("prediction exp %0d got %0d", x.pred, rsp_if.prediction);
                  n_fail++;
               end
               if (rsp_if.epoch_done !== x.done) begin
                  $error("epoch_done exp %0d got %0d", x.done, rsp_if.epoch_done);
                  n_fail++;
               end
               if (rsp_if.converged !== x.conv) begin
                  $error("converged exp %0d got %0d", x.conv, rsp_if.converged);
                  n_fail++;
               end
            end
            n_checked++;
         end
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   function automatic row_type mk(bit mode, int xa, int xb, int tgt, bit last);
      row_type r;
      r.s     = '{mode, 16'(xa), 16'(xb), 32'(tgt), last};
      r.typed = 1'b0;
      r.o     = '{default: 0};
      return r;
   endfunction

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.mode  = 1'b0;
      req_if.x_first       = '0;
      req_if.x_second      = '0;
      req_if.target_value  = '0;
      req_if.last_of_epoch = 1'b0;
      n_sent = 0; n_checked = 0; n_fail = 0; idle_cycles = 0;
      hold_rsp = 1'b0; quiet = 1'b0;
      for (int k = 0; k < NW; k++) begin
         w_model[k]    = 0;
         gsum_model[k] = 0;
      end
      count_model = 0;
      conv_model  = 1'b0;
      lr_reg  = LR_RESET;
      thr_reg = THR_RESET;
      fu_reg  = FU_RESET;

      // directed rows; the first two are known by eye with zero weights
      rows[0]  = mk(1, -32768, 32767, 0, 1);           // predict ignores last
      rows[0].typed = 1'b1;
      rows[0].o     = '{0, 0, 0};
      rows[1]  = mk(0, 32767, -32768, 32'h7FFF_FFFF, 1); // huge error, no convergence
      rows[1].typed = 1'b1;
      rows[1].o     = '{0, 1, 0};
      rows[2]  = mk(0, -32768, 0, 32'h8000_0000, 0);
      rows[3]  = mk(0, 0, 12345, 12345678, 0);
      rows[4]  = mk(0, 1, -1, -1, 1);
      rows[5]  = mk(1, 16384, -16384, 99, 1);
      // two features, top learning rate, threshold zero never converges
      rows[6]  = mk(0, -32768, -32768, 32'h7FFF_FFFF, 0);
      rows[7]  = mk(0, 32767, 32767, 32'h8000_0000, 1);
      rows[8]  = mk(0, -1, -1, 0, 0);
      rows[9]  = mk(1, 32767, -32768, 0, 0);
      rows[10] = mk(0, 12000, -20000, 32'h0100_0000, 1);
      // features_used 3 acts as 2, learning rate zero freezes weights
      rows[11] = mk(0, -32768, 16384, 5 << 24, 1);
      rows[12] = mk(1, 20000, 30000, 0, 0);
      // features_used 0 acts as 1
      rows[13] = mk(0, 32767, -32768, -(3 << 24), 1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (i == 6) begin
            drain();
            program_regs(16'hFFFF, 32'd0, 2'd2, 1'b0);
         end else if (i == 11) begin
            drain();
            program_regs(16'd0, 32'd0, 2'd3, 1'b0);
         end else if (i == 13) begin
            drain();
            program_regs(16'd500, 32'd0, 2'd0, 1'b1);
         end
         send(rows[i].s, rows[i].typed, rows[i].o);
      end

      // random phases; the zero-threshold ones stay out of reach, the last one is widest
      drain();
      program_regs(16'd66, 32'd0, 2'd2, 1'b0);
      run_epochs(200, 1'b0);
      drain();
      program_regs(16'hFFFF, 32'd0, 2'd3, 1'b0);
      hold_rsp = 1'b1;   // long hold-off while requests keep coming
      run_epochs(200, 1'b0);
      drain();
      program_regs(16'd0, 32'd0, 2'd0, 1'b0);
      run_epochs(150, 1'b0);
      drain();
      quiet = 1'b1;
      program_regs(16'd4000, $urandom_range(0, 4000), 2'd1, 1'b1);
      run_epochs(200, 1'b0);
      drain();
      quiet = 1'b0;
      program_regs(16'($urandom), $urandom_range(0, 100000), 2'd2, 1'b0);
      run_epochs(200, 1'b0);
      drain();
      program_regs(16'd20000, 32'd0, 2'd1, 1'b0);
      run_epochs(200, 1'b0);
      drain();
      program_regs(16'd12000, 32'd1, 2'd2, 1'b0);
      run_epochs(200, 1'b0);
      drain();
      // zero targets and the widest threshold let the model converge and freeze
      program_regs(16'd30000, 32'hFFFF_FFFF, 2'd2, 1'b0);
      run_epochs(500, 1'b1);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (n_checked != n_sent) @(posedge clock);
      repeat (20) @(posedge clock);
      if (n_fail == 0 && expected_outcomes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
